FILE: src/mrbwt_pkg.sv
`default_nettype none
package mrbwt_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned BYTES_W   = 24;
  localparam int unsigned TICKS_W   = 40;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT     = 3'd4;

  localparam logic MODE_MESSAGE = 1'b0;
  localparam logic MODE_BYTES   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [BYTES_W-1:0] size;
  } entry_t;

  // per-cell control: shift takes the neighbor's entry, load takes the new one
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_EXPIRE,
    ST_DECIDE,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

FILE: src/message_rate_and_byte_window_throttle.sv
// An accepted item goes to ST_RESULT directly with output disabled, via ST_MSG in message
// mode, or via ST_EXPIRE (one expired entry popped a cycle) and ST_DECIDE in byte mode.
// The next item is accepted only once a result has entered the output register,
// which takes a new result only when free; a finished result may wait there meanwhile.
// Reset (rst, synchronous, active high) clears configuration, last forward time, history
// count and window byte sum and holds both ready outputs low; history cells are not cleared.
`default_nettype none
module message_rate_and_byte_window_throttle #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [mrbwt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mrbwt_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [mrbwt_pkg::TIME_W-1:0]          arrival_time,
  input  wire logic [mrbwt_pkg::BYTES_W-1:0]         message_bytes,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       forwarded,
  output logic                                       time_jump,
  output logic                                       queue_full_drop
);

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_DEPTH);

  // configuration
  logic                               mode;
  logic                               output_enabled;
  logic [mrbwt_pkg::TICKS_W-1:0]      period_ticks;
  logic [mrbwt_pkg::TICKS_W-1:0]      window_ticks;
  logic [mrbwt_pkg::LIMIT_W-1:0]      byte_limit;

  // block state
  mrbwt_pkg::state_t                  state, state_next;
  logic [mrbwt_pkg::TIME_W-1:0]       last_forward_time, last_forward_time_next;
  logic [CNT_W-1:0]                   history_count, history_count_next;
  logic [mrbwt_pkg::SUM_W-1:0]        window_byte_sum, window_byte_sum_next;

  // current item
  logic [mrbwt_pkg::TIME_W-1:0]       now;
  logic [mrbwt_pkg::BYTES_W-1:0]      size;
  logic [mrbwt_pkg::TIME_W-1:0]       limit;
  logic                               window_open;
  logic                               res_fwd, res_fwd_next;
  logic                               res_jump, res_jump_next;
  logic                               res_full, res_full_next;

  logic                               in_accept;
  logic                               pop;
  logic                               push;
  logic                               load_out;
  mrbwt_pkg::entry_t                  fresh;
  mrbwt_pkg::entry_t                  oldest;

  logic                               jump_back;
  logic [mrbwt_pkg::TIME_W-1:0]       since_last;
  logic [mrbwt_pkg::TIME_W:0]         limit_diff;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == mrbwt_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= mrbwt_pkg::MODE_MESSAGE;
      output_enabled <= 1'b0;
      period_ticks   <= '0;
      window_ticks   <= '0;
      byte_limit     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrbwt_pkg::CFG_MODE:           mode           <= cfg_data[0];
        mrbwt_pkg::CFG_OUTPUT_ENABLED: output_enabled <= cfg_data[0];
        mrbwt_pkg::CFG_PERIOD_TICKS:   period_ticks   <= cfg_data;
        mrbwt_pkg::CFG_WINDOW_TICKS:   window_ticks   <= cfg_data;
        mrbwt_pkg::CFG_BYTE_LIMIT:     byte_limit     <= cfg_data[mrbwt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // latch the item and its expiry bound; the borrow says the window has not elapsed yet
  assign limit_diff = {1'b0, arrival_time}
                    - {1'b0, {(mrbwt_pkg::TIME_W-mrbwt_pkg::TICKS_W){1'b0}}, window_ticks};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now         <= arrival_time;
      size        <= message_bytes;
      limit       <= limit_diff[mrbwt_pkg::TIME_W-1:0];
      window_open <= !limit_diff[mrbwt_pkg::TIME_W];
    end
  end

  assign jump_back  = (last_forward_time > now);
  assign since_last = jump_back ? '0 : (now - last_forward_time);

  assign fresh.stamp = now;
  assign fresh.size  = size;

  always_comb begin
    state_next             = state;
    last_forward_time_next = last_forward_time;
    history_count_next     = history_count;
    window_byte_sum_next   = window_byte_sum;
    res_fwd_next           = res_fwd;
    res_jump_next          = res_jump;
    res_full_next          = res_full;
    pop                    = 1'b0;
    push                   = 1'b0;
    load_out               = 1'b0;

    unique case (state)
      mrbwt_pkg::ST_IDLE: begin
        if (in_accept) begin
          res_fwd_next  = 1'b0;
          res_jump_next = 1'b0;
          res_full_next = 1'b0;
          if (!output_enabled) begin
            state_next = mrbwt_pkg::ST_RESULT;
          end else if (mode == mrbwt_pkg::MODE_MESSAGE) begin
            state_next = mrbwt_pkg::ST_MSG;
          end else begin
            state_next = mrbwt_pkg::ST_EXPIRE;
          end
        end
      end
      mrbwt_pkg::ST_MSG: begin
        res_jump_next = jump_back;
        res_fwd_next  = (since_last
                         >= {{(mrbwt_pkg::TIME_W-mrbwt_pkg::TICKS_W){1'b0}}, period_ticks});
        if (jump_back || res_fwd_next) begin
          last_forward_time_next = now;
        end
        state_next = mrbwt_pkg::ST_RESULT;
      end
      mrbwt_pkg::ST_EXPIRE: begin
        // drop the oldest entry while it lies before the window
        if (window_open && (history_count != '0) && (oldest.stamp < limit)) begin
          pop                  = 1'b1;
          history_count_next   = history_count - CNT_W'(1);
          window_byte_sum_next = window_byte_sum
                               - {{(mrbwt_pkg::SUM_W-mrbwt_pkg::BYTES_W){1'b0}}, oldest.size};
        end else begin
          state_next = mrbwt_pkg::ST_DECIDE;
        end
      end
      mrbwt_pkg::ST_DECIDE: begin
        if (window_byte_sum < {1'b0, byte_limit}) begin
          if (history_count == FULL_COUNT) begin
            res_full_next = 1'b1;
          end else begin
            push                 = 1'b1;
            res_fwd_next         = 1'b1;
            history_count_next   = history_count + CNT_W'(1);
            window_byte_sum_next = window_byte_sum
                                 + {{(mrbwt_pkg::SUM_W-mrbwt_pkg::BYTES_W){1'b0}}, size};
          end
        end
        state_next = mrbwt_pkg::ST_RESULT;
      end
      mrbwt_pkg::ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = mrbwt_pkg::ST_IDLE;
        end
      end
      default: state_next = mrbwt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= mrbwt_pkg::ST_IDLE;
      last_forward_time <= '0;
      history_count     <= '0;
      window_byte_sum   <= '0;
    end else begin
      state             <= state_next;
      last_forward_time <= last_forward_time_next;
      history_count     <= history_count_next;
      window_byte_sum   <= window_byte_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    res_fwd  <= res_fwd_next;
    res_jump <= res_jump_next;
    res_full <= res_full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      forwarded       <= res_fwd;
      time_jump       <= res_jump;
      queue_full_drop <= res_full;
    end
  end

  mrbwt_chain #(
    .DEPTH (HISTORY_DEPTH),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk    (clk),
    .pop    (pop),
    .push   (push),
    .fill   (history_count),
    .fresh  (fresh),
    .oldest (oldest)
  );

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    history_count <= FULL_COUNT)
    else $error("history count above depth");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (history_count == '0) |-> (window_byte_sum == '0))
    else $error("window byte sum nonzero with empty history");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != mrbwt_pkg::ST_IDLE))
    else $error("accepted item left no work in progress");

  a_no_push_and_pop: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("history push and pop in one cycle");

endmodule
`default_nettype wire

FILE: src/mrbwt_cell.sv
`default_nettype none
module mrbwt_cell (
  input  wire logic                clk,
  input  wire mrbwt_pkg::cell_ctrl_t ctrl,
  input  wire mrbwt_pkg::entry_t   neighbor,
  input  wire mrbwt_pkg::entry_t   fresh,
  output mrbwt_pkg::entry_t        entry
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= fresh;
    end else if (ctrl.shift) begin
      entry <= neighbor;
    end
  end

endmodule
`default_nettype wire

FILE: src/mrbwt_chain.sv
`default_nettype none
module mrbwt_chain #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic              clk,
  input  wire logic              pop,
  input  wire logic              push,
  input  wire logic [CNT_W-1:0]  fill,
  input  wire mrbwt_pkg::entry_t fresh,
  output mrbwt_pkg::entry_t      oldest
);

  mrbwt_pkg::entry_t cells [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      mrbwt_pkg::cell_ctrl_t ctrl;
      mrbwt_pkg::entry_t     neighbor;

      // the new entry lands in the first free cell
      assign ctrl.load  = push && (fill == CNT_W'(i));
      assign ctrl.shift = pop;

      if (i == DEPTH - 1) begin : g_last
        assign neighbor = '0;
      end else begin : g_inner
        assign neighbor = cells[i+1];
      end

      mrbwt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .neighbor (neighbor),
        .fresh    (fresh),
        .entry    (cells[i])
      );
    end
  endgenerate

  assign oldest = cells[0];

endmodule
`default_nettype wire
